### rtl/core/lpkc_pkg.sv
package lpkc_pkg;

  localparam int PWM_PERIOD   = 100;
  localparam int BLINK_PERIOD = 10000;

  localparam int PWM_W   = $clog2(PWM_PERIOD);
  localparam int BLINK_W = $clog2(BLINK_PERIOD);
  localparam int SP_W    = 10;
  localparam int SCAN_W  = 10;
  localparam int KEY_W   = 7;

  localparam logic [SCAN_W-1:0] SCAN_PERIOD_RST = SCAN_W'(100);

  localparam logic [SP_W-1:0] SP_RESET = SP_W'(300);
  localparam logic [SP_W-1:0] SP_STEP  = SP_W'(50);
  localparam logic [SP_W:0]   SP_LIMIT = (SP_W+1)'(600);

  localparam logic [BLINK_W-1:0] BLINK_LAST = BLINK_W'(BLINK_PERIOD - 1);
  localparam logic [BLINK_W-1:0] BLINK_HALF = BLINK_W'(BLINK_PERIOD / 2);
  localparam logic [PWM_W-1:0]   PWM_LAST   = PWM_W'(PWM_PERIOD - 1);

  // key codes after inversion, one-hot per key
  localparam logic [KEY_W-1:0] KEY_AUTO   = 7'h01;
  localparam logic [KEY_W-1:0] KEY_LAMP   = 7'h02;
  localparam logic [KEY_W-1:0] KEY_SET    = 7'h10;
  localparam logic [KEY_W-1:0] KEY_UP     = 7'h20;
  localparam logic [KEY_W-1:0] KEY_DOWN   = 7'h40;
  localparam int               KEY_FWD_BIT = 2;
  localparam int               KEY_REV_BIT = 3;

  // setpoint / 6 as multiply by reciprocal: floor(x * 683 / 4096) is exact below 1024
  localparam int DUTY_RECIP = 683;
  localparam int DUTY_SHIFT = 12;
  localparam int DUTY_W     = 8;

  typedef struct packed {
    logic [KEY_W-1:0] key_lines;
    logic             presence;
  } src_word_t;

  typedef struct packed {
    logic            lamp_lit;
    logic            motor_left;
    logic            motor_right;
    logic            auto_mode;
    logic            setting_active;
    logic [SP_W-1:0] setpoint;
    logic            value_visible;
  } dst_word_t;

  // key state after the current tick, handed to the drive logic
  typedef struct packed {
    logic            auto_flag;
    logic            manual_lamp;
    logic            setting_flag;
    logic [SP_W-1:0] setpoint;
    logic            blink_clear;
  } key_state_t;

  function automatic logic [DUTY_W-1:0] duty_of(input logic [SP_W-1:0] sp);
    logic [SP_W+DUTY_SHIFT-1:0] prod;
    prod = (SP_W+DUTY_SHIFT)'(sp) * (SP_W+DUTY_SHIFT)'(DUTY_RECIP);
    return prod[DUTY_SHIFT +: DUTY_W];
  endfunction

endpackage

### rtl/core/lpkc_keys.sv
module lpkc_keys (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      adv,
  input  logic [lpkc_pkg::SCAN_W-1:0] scan_period,
  input  logic [lpkc_pkg::KEY_W-1:0]  key_lines,
  output lpkc_pkg::key_state_t      ks_next
);
  import lpkc_pkg::*;

  localparam logic [1:0] KP_IDLE    = 2'd0;
  localparam logic [1:0] KP_PRESSED = 2'd1;
  localparam logic [1:0] KP_WAIT    = 2'd2;

  logic [1:0]        key_phase, key_phase_next;
  logic [SCAN_W-1:0] scan_count, scan_count_next;
  logic              auto_flag, manual_lamp, setting_flag;
  logic [SP_W-1:0]   setpoint_reg;

  logic [KEY_W-1:0]  pressed;
  logic [SCAN_W-1:0] period;
  logic              due, act;

  assign pressed = ~key_lines;
  assign period  = (scan_period == '0) ? SCAN_W'(1) : scan_period;
  assign due     = ({1'b0, scan_count} + (SCAN_W+1)'(1)) >= {1'b0, period};
  assign scan_count_next = due ? '0 : scan_count + SCAN_W'(1);

  always_comb begin
    key_phase_next = key_phase;
    act = 1'b0;
    if (due) begin
      unique case (key_phase)
        KP_IDLE: begin
          if (pressed != '0) key_phase_next = KP_PRESSED;
        end
        KP_PRESSED: begin
          if (pressed == '0) begin
            key_phase_next = KP_IDLE;
          end else begin
            key_phase_next = KP_WAIT;
            act = 1'b1;
          end
        end
        default: begin
          if (pressed == '0) key_phase_next = KP_IDLE;
        end
      endcase
    end
  end

  always_comb begin
    ks_next.auto_flag    = auto_flag;
    ks_next.manual_lamp  = manual_lamp;
    ks_next.setting_flag = setting_flag;
    ks_next.setpoint     = setpoint_reg;
    ks_next.blink_clear  = 1'b0;
    if (act) begin
      // a combination of keys matches no arm and does nothing
      unique case (pressed)
        KEY_AUTO: ks_next.auto_flag = ~auto_flag;
        KEY_LAMP: begin
          if (!auto_flag) ks_next.manual_lamp = ~manual_lamp;
        end
        KEY_SET: begin
          ks_next.setting_flag = ~setting_flag;
          ks_next.blink_clear  = 1'b1;
        end
        KEY_UP: begin
          if (setting_flag && ({1'b0, setpoint_reg} + {1'b0, SP_STEP}) < SP_LIMIT)
            ks_next.setpoint = setpoint_reg + SP_STEP;
        end
        KEY_DOWN: begin
          if (setting_flag && setpoint_reg > SP_STEP)
            ks_next.setpoint = setpoint_reg - SP_STEP;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      key_phase    <= KP_IDLE;
      scan_count   <= '0;
      auto_flag    <= 1'b0;
      manual_lamp  <= 1'b0;
      setting_flag <= 1'b0;
      setpoint_reg <= SP_RESET;
    end else if (adv) begin
      key_phase    <= key_phase_next;
      scan_count   <= scan_count_next;
      auto_flag    <= ks_next.auto_flag;
      manual_lamp  <= ks_next.manual_lamp;
      setting_flag <= ks_next.setting_flag;
      setpoint_reg <= ks_next.setpoint;
    end
  end

endmodule

### rtl/core/lpkc_drive.sv
module lpkc_drive (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 adv,
  input  lpkc_pkg::src_word_t  src_word,
  input  lpkc_pkg::key_state_t ks_next,
  output lpkc_pkg::dst_word_t  result
);
  import lpkc_pkg::*;

  localparam logic [1:0] MOTOR_STOP = 2'd0;
  localparam logic [1:0] MOTOR_FWD  = 2'd1;
  localparam logic [1:0] MOTOR_REV  = 2'd2;

  logic [1:0]         motor_state, motor_state_next;
  logic [PWM_W-1:0]   pwm_phase, pwm_phase_next;
  logic [BLINK_W-1:0] blink_count, blink_count_next, blink_base;
  logic               fwd_key, rev_key, enable;
  logic [DUTY_W-1:0]  duty;

  assign fwd_key = ~src_word.key_lines[KEY_FWD_BIT];
  assign rev_key = ~src_word.key_lines[KEY_REV_BIT];

  // both keys down holds the previous drive
  always_comb begin
    unique if (fwd_key && !rev_key) motor_state_next = MOTOR_FWD;
    else if (rev_key && !fwd_key)   motor_state_next = MOTOR_REV;
    else if (!fwd_key && !rev_key)  motor_state_next = MOTOR_STOP;
    else                            motor_state_next = motor_state;
  end

  assign enable = ks_next.auto_flag ? src_word.presence : ks_next.manual_lamp;
  assign duty   = enable ? duty_of(ks_next.setpoint) : '0;

  assign pwm_phase_next = (pwm_phase >= PWM_LAST) ? '0 : pwm_phase + PWM_W'(1);

  assign blink_base = ks_next.blink_clear ? '0 : blink_count;
  always_comb begin
    blink_count_next = blink_base;
    if (ks_next.setting_flag)
      blink_count_next = (blink_base >= BLINK_LAST) ? '0 : blink_base + BLINK_W'(1);
  end

  always_comb begin
    result.lamp_lit       = duty > DUTY_W'(pwm_phase);
    result.motor_left     = (motor_state_next == MOTOR_FWD);
    result.motor_right    = (motor_state_next == MOTOR_REV);
    result.auto_mode      = ks_next.auto_flag;
    result.setting_active = ks_next.setting_flag;
    result.setpoint       = ks_next.setpoint;
    result.value_visible  = blink_count_next < BLINK_HALF;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      motor_state <= MOTOR_STOP;
      pwm_phase   <= '0;
      blink_count <= '0;
    end else if (adv) begin
      motor_state <= motor_state_next;
      pwm_phase   <= pwm_phase_next;
      blink_count <= blink_count_next;
    end
  end

endmodule

### rtl/core/lamp_pwm_key_controller_top.sv
// Lamp, motor and key controller. Each src word is one timer tick (active-low key lines and
// presence bit) and yields exactly one dst word with the state after that tick. A word is
// taken into an input register and computed in one pass into the result register, so dst_valid
// rises once the word has passed both registers, and one word per cycle is sustained while
// dst_stall stays low. Under a downstream stall the result register holds its word and the
// input register takes one more before src_stall rises. scan_period (cfg_wr_data) sets how
// many ticks pass between key samples, zero counting as one; write it only while no word is
// in flight.
module lamp_pwm_key_controller_top (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_wr_en,
  input  logic [lpkc_pkg::SCAN_W-1:0] cfg_wr_data,
  input  logic                        src_valid,
  output logic                        src_stall,
  input  lpkc_pkg::src_word_t         src_data,
  output logic                        dst_valid,
  input  logic                        dst_stall,
  output lpkc_pkg::dst_word_t         dst_data
);
  import lpkc_pkg::*;

  logic [SCAN_W-1:0] scan_period;
  logic              hold_valid;
  src_word_t         hold_word;
  logic              adv, take;
  key_state_t        ks_next;
  dst_word_t         result;

  assign src_stall = hold_valid & dst_valid & dst_stall;
  assign take      = src_valid & ~src_stall;
  assign adv       = hold_valid & ~(dst_valid & dst_stall);

  always_ff @(posedge clk) begin
    if (rst) begin
      scan_period <= SCAN_PERIOD_RST;
    end else if (cfg_wr_en) begin
      scan_period <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (take) begin
      hold_valid <= 1'b1;
    end else if (adv) begin
      hold_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) hold_word <= src_data;
  end

  lpkc_keys u_keys (
    .clk         (clk),
    .rst         (rst),
    .adv         (adv),
    .scan_period (scan_period),
    .key_lines   (hold_word.key_lines),
    .ks_next     (ks_next)
  );

  lpkc_drive u_drive (
    .clk      (clk),
    .rst      (rst),
    .adv      (adv),
    .src_word (hold_word),
    .ks_next  (ks_next),
    .result   (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      dst_valid <= 1'b0;
    end else if (adv) begin
      dst_valid <= 1'b1;
    end else if (!dst_stall) begin
      dst_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) dst_data <= result;
  end

  a_sp_range: assert property (@(posedge clk) disable iff (rst)
    dst_valid |-> (dst_data.setpoint >= SP_STEP && dst_data.setpoint <= SP_W'(550)))
    else $error("setpoint out of range");

  a_motor_excl: assert property (@(posedge clk) disable iff (rst)
    dst_valid |-> !(dst_data.motor_left && dst_data.motor_right))
    else $error("both motor lines driven");

  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    src_stall |-> (hold_valid && dst_valid && dst_stall))
    else $error("src stalled without downstream backpressure");

  a_hold_moves: assert property (@(posedge clk) disable iff (rst)
    (hold_valid && !dst_valid) |=> dst_valid)
    else $error("held word not moved into free result register");

endmodule
